/* sv/klk_pkg.sv */
// Shared types and constants for the keypad PIN lock controller.
package klk_pkg;

    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_ADMIN = 8'h41;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;

    localparam logic [7:0] CFG_MAX_ATTEMPTS   = 8'd0;
    localparam logic [7:0] CFG_LOCKOUT_TICKS  = 8'd1;
    localparam logic [7:0] CFG_OPEN_TICKS     = 8'd2;
    localparam logic [7:0] CFG_MIN_NEW_LENGTH = 8'd3;

    localparam logic [3:0] RST_MAX_ATTEMPTS   = 4'd3;
    localparam logic [7:0] RST_LOCKOUT_TICKS  = 8'd30;
    localparam logic [7:0] RST_OPEN_TICKS     = 8'd3;
    localparam logic [3:0] RST_MIN_NEW_LENGTH = 4'd4;
    localparam logic [3:0] RST_PIN_LENGTH     = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_OPEN_ENTRY  = 3'd1,
        ST_ADMIN_ENTRY = 3'd2,
        ST_NEW_PIN     = 3'd3,
        ST_OPENING     = 3'd4,
        ST_LOCKOUT     = 3'd5
    } t_lock_state;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_DIGIT       = 4'd1,
        EV_CLEARED     = 4'd2,
        EV_OPENED      = 4'd3,
        EV_WRONG       = 4'd4,
        EV_LOCKOUT     = 4'd5,
        EV_ADMIN_OK    = 4'd6,
        EV_ADMIN_WRONG = 4'd7,
        EV_TOO_SHORT   = 4'd8,
        EV_CHANGED     = 4'd9,
        EV_CLOSED      = 4'd10
    } t_event;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_DIGIT = 3'd1,
        CMD_STAR  = 3'd2,
        CMD_HASH  = 3'd3,
        CMD_ADMIN = 3'd4,
        CMD_TICK  = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] digit;
    } t_item;

    typedef struct packed {
        logic [3:0] max_attempts;
        logic [7:0] lockout_ticks;
        logic [7:0] open_ticks;
        logic [3:0] min_new_length;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [3:0]  tries_left;
        logic [3:0]  digits_entered;
        t_lock_state lock_state;
        logic [7:0]  seconds_left;
        logic        locked_out;
        logic        door_open;
    } t_result;

endpackage

/* sv/klk_front.sv */
// Front end: classifies incoming keys and ticks and queues them for the back end.
module klk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  logic [7:0]    i_key_code,
    output logic          o_item_valid,
    input  logic          i_item_ready,
    output klk_pkg::t_item o_item
);
    import klk_pkg::*;

    t_item       w_item;
    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_push;
    logic        w_pop;

    always_comb begin
        w_item.digit = 4'(i_key_code - KEY_ZERO);
        if (i_mode) begin
            w_item.cmd = CMD_TICK;
        end else if (i_key_code >= KEY_ZERO && i_key_code <= KEY_NINE) begin
            w_item.cmd = CMD_DIGIT;
        end else if (i_key_code == KEY_STAR) begin
            w_item.cmd = CMD_STAR;
        end else if (i_key_code == KEY_HASH) begin
            w_item.cmd = CMD_HASH;
        end else if (i_key_code == KEY_ADMIN) begin
            w_item.cmd = CMD_ADMIN;
        end else begin
            w_item.cmd = CMD_NONE;
        end
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2))
        else $error("full queue changed without a pop");

endmodule

/* sv/klk_back.sv */
// Back end: lock state machine, PIN storage and the registered result stage.
module klk_back #(
    parameter int MAX_DIGITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  klk_pkg::t_cfg    i_cfg,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  klk_pkg::t_item   i_item,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output klk_pkg::t_result o_res
);
    import klk_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);

    t_lock_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pin_len, n_pin_len;
    logic [3:0]    r_att, n_att;
    logic [3:0]    w_att_dec;
    logic [7:0]    r_timer, n_timer;
    logic [3:0]    r_entry [MAX_DIGITS];
    logic [3:0]    r_pin [MAX_DIGITS];
    logic          r_out_valid;
    t_result       r_out, n_out;
    t_event        w_ev;
    logic          w_fire;
    logic          w_match;
    logic          w_wr_digit;
    logic          w_wr_pin;
    logic [15:0]   w_count_wide;
    logic [15:0]   w_next_count_wide;
    logic [15:0]   w_min_wide;
    logic          w_timed;

    assign o_item_ready = !r_out_valid || i_res_ready;
    assign w_fire       = i_item_valid && o_item_ready;
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;
    assign w_count_wide = 16'(r_count);
    assign w_min_wide   = 16'(i_cfg.min_new_length);
    assign w_att_dec    = (r_att != 4'd0) ? r_att - 4'd1 : r_att;

    always_comb begin
        w_match = (r_count == r_pin_len);
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (CW'(k) < r_count && r_entry[k] != r_pin[k]) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pin_len  = r_pin_len;
        n_att      = r_att;
        n_timer    = r_timer;
        w_ev       = EV_NONE;
        w_wr_digit = 1'b0;
        w_wr_pin   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item.cmd == CMD_STAR) begin
                    n_state = ST_OPEN_ENTRY;
                    n_count = '0;
                end else if (i_item.cmd == CMD_ADMIN) begin
                    n_state = ST_ADMIN_ENTRY;
                    n_count = '0;
                end
            end
            ST_OPEN_ENTRY, ST_ADMIN_ENTRY, ST_NEW_PIN: begin
                unique case (i_item.cmd)
                    CMD_HASH: begin
                        n_count = '0;
                        if (r_state == ST_OPEN_ENTRY) begin
                            if (w_match) begin
                                n_state = ST_OPENING;
                                n_timer = i_cfg.open_ticks;
                                n_att   = i_cfg.max_attempts;
                                w_ev    = EV_OPENED;
                            end else begin
                                n_att = w_att_dec;
                                if (w_att_dec == 4'd0) begin
                                    n_state = ST_LOCKOUT;
                                    n_timer = i_cfg.lockout_ticks;
                                    w_ev    = EV_LOCKOUT;
                                end else begin
                                    w_ev = EV_WRONG;
                                end
                            end
                        end else if (r_state == ST_ADMIN_ENTRY) begin
                            if (w_match) begin
                                n_state = ST_NEW_PIN;
                                w_ev    = EV_ADMIN_OK;
                            end else begin
                                n_state = ST_IDLE;
                                w_ev    = EV_ADMIN_WRONG;
                            end
                        end else begin
                            if (w_count_wide < w_min_wide) begin
                                w_ev = EV_TOO_SHORT;
                            end else begin
                                w_wr_pin  = 1'b1;
                                n_pin_len = r_count;
                                n_state   = ST_IDLE;
                                w_ev      = EV_CHANGED;
                            end
                        end
                    end
                    CMD_STAR: begin
                        n_count = '0;
                        w_ev    = EV_CLEARED;
                    end
                    CMD_DIGIT: begin
                        if (w_count_wide < 16'(MAX_DIGITS)) begin
                            w_wr_digit = 1'b1;
                            n_count    = r_count + CW'(1);
                            w_ev       = EV_DIGIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_OPENING, ST_LOCKOUT: begin
                if (i_item.cmd == CMD_TICK) begin
                    if (r_timer > 8'd1) begin
                        n_timer = r_timer - 8'd1;
                    end else begin
                        n_timer = 8'd0;
                        n_state = ST_IDLE;
                        if (r_state == ST_OPENING) begin
                            w_ev = EV_CLOSED;
                        end else begin
                            n_att   = i_cfg.max_attempts;
                            n_count = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_next_count_wide = 16'(n_count);
    assign w_timed = (n_state == ST_OPENING) || (n_state == ST_LOCKOUT);

    always_comb begin
        n_out.door_open      = (n_state == ST_OPENING);
        n_out.locked_out     = (n_state == ST_LOCKOUT);
        n_out.seconds_left   = w_timed ? n_timer : 8'd0;
        n_out.lock_state     = n_state;
        n_out.digits_entered = w_next_count_wide[3:0];
        n_out.tries_left     = n_att;
        n_out.event_res      = w_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pin_len   <= CW'(RST_PIN_LENGTH);
            r_att       <= RST_MAX_ATTEMPTS;
            r_timer     <= 8'd0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_pin[k] <= (k < 4) ? 4'(k + 1) : 4'd0;
            end
        end else begin
            if (w_fire) begin
                r_state   <= n_state;
                r_count   <= n_count;
                r_pin_len <= n_pin_len;
                r_att     <= n_att;
                r_timer   <= n_timer;
                if (w_wr_pin) begin
                    for (int k = 0; k < MAX_DIGITS; k++) begin
                        if (CW'(k) < r_count) begin
                            r_pin[k] <= r_entry[k];
                        end
                    end
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
        if (w_fire && w_wr_digit) begin
            r_entry[r_count[IW-1:0]] <= i_item.digit;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_wide <= 16'(MAX_DIGITS))
        else $error("entry count exceeds buffer size");
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_OPENING || r_state == ST_LOCKOUT)
        |-> (r_count == '0))
        else $error("digits held outside an entry state");
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_OPENING && r_state != ST_LOCKOUT) |-> (r_timer == 8'd0))
        else $error("period timer running outside a timed state");
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out.lock_state == r_state))
        else $error("result state differs from lock state");

endmodule

/* sv/keypad_pin_lock_controller.sv */
// Top level of the keypad PIN lock: configuration registers, front end and back end.
//
//  channel  direction  handshake                      payload
//  s_axis   in         i_s_axis_tvalid/o_s_axis_tready tdata key_code, tuser mode
//  m_axis   out        o_m_axis_tvalid/i_m_axis_tready tdata result fields
//  cfg      in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// One item per cycle is sustained while the output accepts results; an input transfer
// is written into the two-entry queue, and the state update then loads the result register
// from the queue head, which presents the result on the output.
// While a result waits, the queue takes up to two more input transfers, then the input stalls.
// Reset restores the default PIN, register defaults and the idle state at once.
// Configuration transfers are always accepted and take effect on the next cycle.
module keypad_pin_lock_controller #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] key_code
    input  logic        i_s_axis_tuser,   // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] door_open, [1] locked_out, [9:2] seconds_left, [12:10] lock_state,
    // [16:13] digits_entered, [20:17] tries_left, [24:21] event_res, [31:25] zero
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import klk_pkg::*;

    t_cfg    r_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_ready;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_attempts   <= RST_MAX_ATTEMPTS;
            r_cfg.lockout_ticks  <= RST_LOCKOUT_TICKS;
            r_cfg.open_ticks     <= RST_OPEN_TICKS;
            r_cfg.min_new_length <= RST_MIN_NEW_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_ATTEMPTS:   r_cfg.max_attempts   <= i_cfg_data[3:0];
                CFG_LOCKOUT_TICKS:  r_cfg.lockout_ticks  <= i_cfg_data;
                CFG_OPEN_TICKS:     r_cfg.open_ticks     <= i_cfg_data;
                CFG_MIN_NEW_LENGTH: r_cfg.min_new_length <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    klk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_key_code   (i_s_axis_tdata),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    klk_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (w_res)
    );

    assign o_m_axis_tdata = {7'd0, w_res};

endmodule

/* bench/keypad_pin_lock_controller_tb.sv */
// Self-checking testbench for the keypad PIN lock controller with its own lock predictor.
module keypad_pin_lock_controller_tb;
    import klk_pkg::*;

    localparam int MAX_DIGITS  = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    keypad_pin_lock_controller #(.MAX_DIGITS(MAX_DIGITS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    typedef struct {
        logic        mode;
        logic [7:0]  key;
        bit          typed;
        t_lock_state st;
        t_event      ev;
    } t_key_row;

    t_key_row key_rows [25] = '{
        '{1'b0, 8'h00,              1'b1, ST_IDLE,        EV_NONE},
        '{1'b1, 8'hFF,              1'b1, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ADMIN,          1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_NINE,           1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_HASH,           1'b1, ST_IDLE,        EV_ADMIN_WRONG},
        '{1'b0, KEY_STAR,           1'b1, ST_OPEN_ENTRY,  EV_NONE},
        '{1'b0, KEY_HASH,           1'b1, ST_OPEN_ENTRY,  EV_WRONG},
        '{1'b0, 8'hFF,              1'b1, ST_OPEN_ENTRY,  EV_NONE},
        '{1'b0, KEY_ZERO + 8'd1,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd2,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd3,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd4,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_HASH,           1'b1, ST_OPENING,     EV_OPENED},
        '{1'b0, KEY_STAR,           1'b1, ST_OPENING,     EV_NONE},
        '{1'b1, 8'h00,              1'b0, ST_IDLE,        EV_NONE},
        '{1'b1, 8'h55,              1'b0, ST_IDLE,        EV_NONE},
        '{1'b1, 8'hAA,              1'b1, ST_IDLE,        EV_CLOSED},
        '{1'b0, KEY_ADMIN,          1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd1,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd2,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd3,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_ZERO + 8'd4,    1'b0, ST_IDLE,        EV_NONE},
        '{1'b0, KEY_HASH,           1'b1, ST_NEW_PIN,     EV_ADMIN_OK},
        '{1'b0, KEY_HASH,           1'b1, ST_NEW_PIN,     EV_TOO_SHORT},
        '{1'b0, KEY_STAR,           1'b1, ST_NEW_PIN,     EV_CLEARED}
    };

    t_cfg        lock_cfg;
    t_lock_state lock_mode;
    logic [3:0]  entry_dig [MAX_DIGITS];
    int          entry_cnt;
    logic [3:0]  lock_pin [MAX_DIGITS];
    int          pin_len;
    logic [3:0]  tries;
    logic [7:0]  period;

    t_result     pending_results [$];
    logic [7:0]  key_plan [$];
    t_result     want_res;
    t_result     got_res;
    int          fail_count;
    int          checked_count;
    int          opened_count;
    int          lockout_count;
    int          changed_count;
    int          quiet_cycles;
    bit          no_idle;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_lock_model();
        lock_cfg  = '{RST_MAX_ATTEMPTS, RST_LOCKOUT_TICKS, RST_OPEN_TICKS, RST_MIN_NEW_LENGTH};
        lock_mode = ST_IDLE;
        entry_cnt = 0;
        foreach (lock_pin[i]) begin
            lock_pin[i]  = (i < 4) ? 4'(i + 1) : 4'd0;
            entry_dig[i] = 4'd0;
        end
        pin_len  = RST_PIN_LENGTH;
        tries    = RST_MAX_ATTEMPTS;
        period   = 8'd0;
    endfunction

    function automatic t_result next_lock_result(input logic mode, input logic [7:0] key);
        t_event  ev;
        t_result r;
        bit      match;
        ev = EV_NONE;
        if (!mode) begin
            case (lock_mode)
                ST_IDLE: begin
                    if (key == KEY_STAR) begin
                        lock_mode = ST_OPEN_ENTRY;
                        entry_cnt = 0;
                    end else if (key == KEY_ADMIN) begin
                        lock_mode = ST_ADMIN_ENTRY;
                        entry_cnt = 0;
                    end
                end
                ST_OPEN_ENTRY, ST_ADMIN_ENTRY, ST_NEW_PIN: begin
                    if (key == KEY_HASH) begin
                        match = (entry_cnt == pin_len);
                        for (int k = 0; k < entry_cnt; k++)
                            if (entry_dig[k] != lock_pin[k]) match = 1'b0;
                        case (lock_mode)
                            ST_OPEN_ENTRY: begin
                                if (match) begin
                                    lock_mode = ST_OPENING;
                                    period    = lock_cfg.open_ticks;
                                    tries     = lock_cfg.max_attempts;
                                    ev        = EV_OPENED;
                                end else begin
                                    if (tries != 4'd0) tries = tries - 4'd1;
                                    if (tries == 4'd0) begin
                                        lock_mode = ST_LOCKOUT;
                                        period    = lock_cfg.lockout_ticks;
                                        ev        = EV_LOCKOUT;
                                    end else begin
                                        ev = EV_WRONG;
                                    end
                                end
                            end
                            ST_ADMIN_ENTRY: begin
                                lock_mode = match ? ST_NEW_PIN : ST_IDLE;
                                ev        = match ? EV_ADMIN_OK : EV_ADMIN_WRONG;
                            end
                            default: begin
                                if (entry_cnt < lock_cfg.min_new_length) begin
                                    ev = EV_TOO_SHORT;
                                end else begin
                                    for (int k = 0; k < entry_cnt; k++) lock_pin[k] = entry_dig[k];
                                    pin_len   = entry_cnt;
                                    lock_mode = ST_IDLE;
                                    ev        = EV_CHANGED;
                                end
                            end
                        endcase
                        entry_cnt = 0;
                    end else if (key == KEY_STAR) begin
                        entry_cnt = 0;
                        ev        = EV_CLEARED;
                    end else if (key >= KEY_ZERO && key <= KEY_NINE && entry_cnt < MAX_DIGITS) begin
                        entry_dig[entry_cnt] = 4'(key - KEY_ZERO);
                        entry_cnt++;
                        ev = EV_DIGIT;
                    end
                end
                default: ;
            endcase
        end else if (lock_mode == ST_OPENING || lock_mode == ST_LOCKOUT) begin
            if (period > 8'd1) begin
                period = period - 8'd1;
            end else begin
                period = 8'd0;
                if (lock_mode == ST_OPENING) begin
                    ev = EV_CLOSED;
                end else begin
                    tries     = lock_cfg.max_attempts;
                    entry_cnt = 0;
                end
                lock_mode = ST_IDLE;
            end
        end
        r.door_open      = (lock_mode == ST_OPENING);
        r.locked_out     = (lock_mode == ST_LOCKOUT);
        r.seconds_left   = (r.door_open || r.locked_out) ? period : 8'd0;
        r.lock_state     = lock_mode;
        r.digits_entered = 4'(entry_cnt);
        r.tries_left     = tries;
        r.event_res      = ev;
        return r;
    endfunction

    task automatic send_press(input logic mode, input logic [7:0] key, input bit typed,
                              input t_lock_state st, input t_event ev);
        t_result r;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= key;
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = next_lock_result(mode, key);
        case (r.event_res)
            EV_OPENED:  opened_count++;
            EV_LOCKOUT: lockout_count++;
            EV_CHANGED: changed_count++;
            default: ;
        endcase
        if (typed) begin
            r.lock_state = st;
            r.event_res  = ev;
        end
        pending_results.push_back(r);
    endtask

    task automatic settle_lock();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_lock(input t_cfg c);
        logic [7:0] regs [4] = '{CFG_MAX_ATTEMPTS, CFG_LOCKOUT_TICKS, CFG_OPEN_TICKS,
                                 CFG_MIN_NEW_LENGTH};
        logic [7:0] vals [4];
        vals = '{8'(c.max_attempts), c.lockout_ticks, c.open_ticks, 8'(c.min_new_length)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        lock_cfg = c;
    endtask

    task automatic run_lock_traffic(input int target);
        logic       mode;
        logic [7:0] key;
        int         r;
        int         n;
        int         sent;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (key_plan.size() != 0) begin
                mode = (r < 5);
                key  = mode ? 8'($urandom) : key_plan.pop_front();
            end else begin
                case (lock_mode)
                    ST_IDLE: begin
                        mode = (r >= 60 && r < 70);
                        key  = (r < 40) ? KEY_STAR : (r < 60) ? KEY_ADMIN : 8'($urandom);
                    end
                    ST_OPENING, ST_LOCKOUT: begin
                        mode = (r < 85);
                        key  = 8'($urandom);
                    end
                    default: begin
                        if ($urandom_range(0, 19) == 0) key_plan.push_back(KEY_STAR);
                        if (lock_mode != ST_NEW_PIN && $urandom_range(0, 9) < 6) begin
                            for (int i = 0; i < pin_len; i++)
                                key_plan.push_back(KEY_ZERO + 8'(lock_pin[i]));
                        end else begin
                            n = $urandom_range(0, MAX_DIGITS + 2);
                            repeat (n) key_plan.push_back(KEY_ZERO + 8'($urandom_range(0, 9)));
                        end
                        if ($urandom_range(0, 9) == 0) key_plan.push_back(8'($urandom));
                        key_plan.push_back(KEY_HASH);
                        continue;
                    end
                endcase
            end
            send_press(mode, key, 1'b0, ST_IDLE, EV_NONE);
            sent++;
        end
    endtask

    initial begin
        forever begin
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_res = t_result'(o_m_axis_tdata[24:0]);
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want_res = pending_results.pop_front();
                checked_count++;
                if (got_res.door_open !== want_res.door_open) begin
                    $error("door_open: expected %0d, got %0d",
                           want_res.door_open, got_res.door_open);
                    fail_count++;
                end
                if (got_res.locked_out !== want_res.locked_out) begin
                    $error("locked_out: expected %0d, got %0d",
                           want_res.locked_out, got_res.locked_out);
                    fail_count++;
                end
                if (got_res.seconds_left !== want_res.seconds_left) begin
                    $error("seconds_left: expected %0d, got %0d",
                           want_res.seconds_left, got_res.seconds_left);
                    fail_count++;
                end
                if (got_res.lock_state !== want_res.lock_state) begin
                    $error("lock_state: expected %0d, got %0d",
                           want_res.lock_state, got_res.lock_state);
                    fail_count++;
                end
                if (got_res.digits_entered !== want_res.digits_entered) begin
                    $error("digits_entered: expected %0d, got %0d",
                           want_res.digits_entered, got_res.digits_entered);
                    fail_count++;
                end
                if (got_res.tries_left !== want_res.tries_left) begin
                    $error("tries_left: expected %0d, got %0d",
                           want_res.tries_left, got_res.tries_left);
                    fail_count++;
                end
                if (got_res.event_res !== want_res.event_res) begin
                    $error("event_res: expected %0d, got %0d",
                           want_res.event_res, got_res.event_res);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transfer for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg settings [6];
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tuser  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = 8'd0;
        i_cfg_data      = 8'd0;
        quiet_cycles    = 0;
        fail_count      = 0;
        checked_count   = 0;
        no_idle         = 1'b0;
        hold_off        = 1'b0;
        reset_lock_model();

        settings[0] = '{4'd1, 8'd1, 8'd1, 4'd1};
        settings[1] = '{4'd15, 8'd255, 8'd255, 4'd8};
        settings[2] = '{4'd2, 8'd7, 8'd4, 4'd6};
        settings[3] = '{4'($urandom_range(1, 15)), 8'($urandom_range(1, 40)),
                        8'($urandom_range(1, 20)), 4'($urandom_range(1, 8))};
        settings[4] = '{4'($urandom_range(1, 15)), 8'($urandom_range(1, 40)),
                        8'($urandom_range(1, 20)), 4'($urandom_range(1, 8))};
        settings[5] = '{RST_MAX_ATTEMPTS, RST_LOCKOUT_TICKS, RST_OPEN_TICKS, RST_MIN_NEW_LENGTH};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (key_rows[i])
            send_press(key_rows[i].mode, key_rows[i].key, key_rows[i].typed,
                       key_rows[i].st, key_rows[i].ev);

        foreach (settings[p]) begin
            settle_lock();
            program_lock(settings[p]);
            if (p == 2) hold_off = 1'b1;
            if (p == 5) no_idle = 1'b1;
            run_lock_traffic(PHASE_ITEMS);
        end
        settle_lock();
        repeat (8) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Checked %0d results over 7 register settings, including reset defaults.",
                 checked_count);
        $display("Saw %0d openings, %0d lockouts and %0d PIN changes.",
                 opened_count, lockout_count, changed_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
